>>> hdl/cfr_pkg.sv
`default_nettype none

package cfr_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_datagram;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] message_id;
      logic [7:0]  packet_type;
      logic [9:0]  payload_length;
   } rsp_type;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_HEADER_CRC = 2'd1;
   localparam logic [1:0] STATUS_BODY_CRC   = 2'd2;
   localparam logic [1:0] STATUS_LENGTH     = 2'd3;

   localparam logic [7:0]  HDR_CRC_INIT  = 8'h77;
   localparam logic [15:0] BODY_CRC_INIT = 16'h3692;
   localparam logic [7:0]  CRC8_POLY     = 8'h8C;
   localparam logic [15:0] CRC16_POLY    = 16'h8408;
   localparam logic [12:0] MIN_FRAME     = 13'd11;
   localparam logic [10:0] POS_LIMIT     = 11'd2047;

   // Reflected CRC-8 update for one byte; synthesis folds the bit loop into a table.
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC8_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // Reflected CRC-16 update for one byte, table-driven form.
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = {8'h00, crc[7:0] ^ b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC16_POLY) : (c >> 1);
      end
      return c ^ {8'h00, crc[15:8]};
   endfunction

endpackage

`default_nettype wire

>>> hdl/cfr_input_stage.sv
`default_nettype none

module cfr_input_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire cfr_pkg::req_type req_payload,
   input  wire logic             out_free,
   output logic                  byte_move,
   output cfr_pkg::req_type      byte_data
);
   import cfr_pkg::*;

   logic    valid_ff, valid_in;
   req_type data_ff;
   logic    accept;

   // A byte that closes no datagram never waits for the result register.
   assign byte_move = valid_ff && (!data_ff.end_of_datagram || out_free);
   assign req_stall = valid_ff && !byte_move;
   assign accept    = req_valid && !req_stall;
   assign byte_data = data_ff;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (byte_move) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_payload;
      end
   end

endmodule

`default_nettype wire

>>> hdl/cfr_frame_check.sv
`default_nettype none

module cfr_frame_check #(
   parameter int MAX_FRAME = 1024
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             byte_move,
   input  wire cfr_pkg::req_type byte_data,
   output logic                  result_load,
   output cfr_pkg::rsp_type      result_data
);
   import cfr_pkg::*;

   logic [10:0] pos_ff, pos_in;
   logic [12:0] len_ff, len_in;
   logic [7:0]  hdr_ff, hdr_in;
   logic [15:0] body_ff, body_in;
   logic [7:0]  crc_lo_ff, crc_lo_in;
   logic [15:0] id_ff, id_in;
   logic [7:0]  type_ff, type_in;
   logic [1:0]  err_ff, err_in;
   logic        done_ff, done_in;

   logic [7:0]  b;
   logic [12:0] pos_wide;
   logic        len_ok, len_ok_after;
   logic [1:0]  status;
   logic [12:0] payload_wide;

   assign b        = byte_data.data_byte;
   assign pos_wide = {2'b00, pos_ff};
   assign len_ok   = (len_ff >= MIN_FRAME) && (len_ff <= 13'(MAX_FRAME))
                     && (len_ff <= {2'b00, POS_LIMIT});
   assign len_ok_after = (len_in >= MIN_FRAME) && (len_in <= 13'(MAX_FRAME))
                         && (len_in <= {2'b00, POS_LIMIT});

   always_comb begin
      hdr_in    = hdr_ff;
      body_in   = body_ff;
      len_in    = len_ff;
      crc_lo_in = crc_lo_ff;
      id_in     = id_ff;
      type_in   = type_ff;
      err_in    = err_ff;
      done_in   = done_ff;
      if (pos_ff < 11'd3) begin
         hdr_in  = crc8_byte(hdr_ff, b);
         body_in = crc16_byte(body_ff, b);
         if (pos_ff == 11'd1) begin
            len_in = {8'h00, b[7:3]};
         end else if (pos_ff == 11'd2) begin
            len_in = {b, len_ff[4:0]};
         end
      end else if (len_ok && (pos_wide < len_ff)) begin
         if ((pos_ff == 11'd3) && (b != hdr_ff)) begin
            err_in[0] = 1'b1;
         end
         if (pos_ff == 11'd4) begin
            type_in = b;
         end
         if (pos_ff == 11'd5) begin
            id_in[7:0] = b;
         end
         if (pos_ff == 11'd6) begin
            id_in[15:8] = b;
         end
         if (pos_wide < (len_ff - 13'd2)) begin
            body_in = crc16_byte(body_ff, b);
         end else if (pos_wide == (len_ff - 13'd2)) begin
            crc_lo_in = b;
         end else begin
            if ({b, crc_lo_ff} != body_ff) begin
               err_in[1] = 1'b1;
            end
            done_in = 1'b1;
         end
      end
      pos_in = (pos_ff < POS_LIMIT) ? pos_ff + 11'd1 : pos_ff;
   end

   always_comb begin
      if (pos_in < 11'd4) begin
         status = STATUS_LENGTH;
      end else if (err_in[0]) begin
         status = STATUS_HEADER_CRC;
      end else if (!len_ok_after || !done_in) begin
         status = STATUS_LENGTH;
      end else if (err_in[1]) begin
         status = STATUS_BODY_CRC;
      end else begin
         status = STATUS_OK;
      end
   end

   assign payload_wide = len_in - MIN_FRAME;
   assign result_load  = byte_move && byte_data.end_of_datagram;

   always_comb begin
      result_data.status      = status;
      result_data.message_id  = id_in;
      result_data.packet_type = type_in;
      if ((status == STATUS_OK) || (status == STATUS_BODY_CRC)) begin
         result_data.payload_length = payload_wide[9:0];
      end else begin
         result_data.payload_length = 10'd0;
      end
   end

   // The closing byte of a datagram puts the whole frame state back to its reset values.
   always_ff @(posedge clock) begin
      if (reset || result_load) begin
         pos_ff    <= '0;
         len_ff    <= '0;
         hdr_ff    <= HDR_CRC_INIT;
         body_ff   <= BODY_CRC_INIT;
         crc_lo_ff <= '0;
         id_ff     <= '0;
         type_ff   <= '0;
         err_ff    <= '0;
         done_ff   <= 1'b0;
      end else if (byte_move) begin
         pos_ff    <= pos_in;
         len_ff    <= len_in;
         hdr_ff    <= hdr_in;
         body_ff   <= body_in;
         crc_lo_ff <= crc_lo_in;
         id_ff     <= id_in;
         type_ff   <= type_in;
         err_ff    <= err_in;
         done_ff   <= done_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/cfr_output_stage.sv
`default_nettype none

module cfr_output_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             result_load,
   input  wire cfr_pkg::rsp_type result_data,
   output logic                  out_free,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output cfr_pkg::rsp_type      rsp_payload
);
   import cfr_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign out_free    = !valid_ff || !rsp_stall;
   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

   always_comb begin
      if (result_load) begin
         valid_in = 1'b1;
      end else if (out_free) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_load) begin
         data_ff <= result_data;
      end
   end

endmodule

`default_nettype wire

>>> hdl/crc_checked_frame_receiver.sv
// Throughput: one byte per cycle but for the wait below. A last byte passes the input
// register, its result the output register; a CRC takes a table step per byte it covers.
// A byte that ends a datagram waits in the input register only while a result is stalled.
// Reset (synchronous) empties both registers and restores the CRC seeds and frame state.
`default_nettype none

module crc_checked_frame_receiver #(
   parameter int MAX_FRAME = 1024
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire cfr_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output cfr_pkg::rsp_type      rsp_payload
);
   import cfr_pkg::*;

   logic    out_free;
   logic    byte_move;
   req_type byte_data;
   logic    result_load;
   rsp_type result_data;

   cfr_input_stage u_input (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .out_free    (out_free),
      .byte_move   (byte_move),
      .byte_data   (byte_data)
   );

   cfr_frame_check #(
      .MAX_FRAME (MAX_FRAME)
   ) u_check (
      .clock       (clock),
      .reset       (reset),
      .byte_move   (byte_move),
      .byte_data   (byte_data),
      .result_load (result_load),
      .result_data (result_data)
   );

   cfr_output_stage u_output (
      .clock       (clock),
      .reset       (reset),
      .result_load (result_load),
      .result_data (result_data),
      .out_free    (out_free),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

>>> bench/frame_status_checker.sv
`timescale 1ns / 100ps

package frame_crc_pkg;
   import cfr_pkg::*;

   // Bit-serial forms of the two reflected CRCs; data bits enter LSB first.
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] r;
      logic       fb;
      r = crc;
      for (int i = 0; i < 8; i++) begin
         fb = r[0] ^ data[i];
         r  = r >> 1;
         if (fb) begin
            r = r ^ CRC8_POLY;
         end
      end
      return r;
   endfunction

   function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                input logic [7:0] data);
      logic [15:0] r;
      logic        fb;
      r = crc;
      for (int i = 0; i < 8; i++) begin
         fb = r[0] ^ data[i];
         r  = r >> 1;
         if (fb) begin
            r = r ^ CRC16_POLY;
         end
      end
      return r;
   endfunction

endpackage

module frame_status_checker #(
   parameter int MAX_FRAME = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  cfr_pkg::req_type req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  cfr_pkg::rsp_type rsp_payload,
   output int               mismatches,
   output int               outstanding,
   output int               results_checked
);
   import cfr_pkg::*;
   import frame_crc_pkg::*;

   logic [10:0] position;
   logic [12:0] frame_len;
   logic [7:0]  hdr_crc;
   logic [15:0] body_crc;
   logic [7:0]  crc_low;
   logic [15:0] held_id;
   logic [7:0]  held_type;
   logic        hdr_bad;
   logic        body_bad;
   logic        complete;

   rsp_type expected_results[$];

   task automatic clear_frame();
      position  = '0;
      frame_len = '0;
      hdr_crc   = HDR_CRC_INIT;
      body_crc  = BODY_CRC_INIT;
      crc_low   = '0;
      held_id   = '0;
      held_type = '0;
      hdr_bad   = 1'b0;
      body_bad  = 1'b0;
      complete  = 1'b0;
   endtask

   function automatic logic length_ok();
      return frame_len >= MIN_FRAME && frame_len <= MAX_FRAME && frame_len <= POS_LIMIT;
   endfunction

   // Advances the frame state by one request byte and, on the last byte of a
   // datagram, queues the status that the block must report.
   task automatic absorb_byte(input logic [7:0] b, input logic last);
      rsp_type     want;
      logic [12:0] payload;
      if (position < 3) begin
         hdr_crc  = crc8_update(hdr_crc, b);
         body_crc = crc16_update(body_crc, b);
         if (position == 1) begin
            frame_len = {5'd0, b} >> 3;
         end else if (position == 2) begin
            frame_len = {b, 5'd0} | frame_len;
         end
      end else if (length_ok() && position < frame_len) begin
         if (position == 3 && b != hdr_crc) begin
            hdr_bad = 1'b1;
         end
         if (position == 4) begin
            held_type = b;
         end
         if (position == 5) begin
            held_id[7:0] = b;
         end
         if (position == 6) begin
            held_id[15:8] = b;
         end
         if (position < frame_len - 13'd2) begin
            body_crc = crc16_update(body_crc, b);
         end else if (position == frame_len - 13'd2) begin
            crc_low = b;
         end else begin
            if ({b, crc_low} != body_crc) begin
               body_bad = 1'b1;
            end
            complete = 1'b1;
         end
      end
      if (position < POS_LIMIT) begin
         position = position + 11'd1;
      end
      if (last) begin
         if (position < 4) begin
            want.status = STATUS_LENGTH;
         end else if (hdr_bad) begin
            want.status = STATUS_HEADER_CRC;
         end else if (!length_ok() || !complete) begin
            want.status = STATUS_LENGTH;
         end else if (body_bad) begin
            want.status = STATUS_BODY_CRC;
         end else begin
            want.status = STATUS_OK;
         end
         payload             = frame_len - MIN_FRAME;
         want.message_id     = held_id;
         want.packet_type    = held_type;
         want.payload_length = (want.status == STATUS_OK || want.status == STATUS_BODY_CRC) ?
                               payload[9:0] : 10'd0;
         expected_results.push_back(want);
         clear_frame();
      end
   endtask

   initial begin
      mismatches      = 0;
      outstanding     = 0;
      results_checked = 0;
      clear_frame();
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_frame();
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("unexpected result: status %0d id %h type %h length %0d",
                           rsp_payload.status, rsp_payload.message_id,
                           rsp_payload.packet_type, rsp_payload.payload_length);
               end
            end else begin
               want = expected_results.pop_front();
               if (rsp_payload.status !== want.status ||
                   rsp_payload.message_id !== want.message_id ||
                   rsp_payload.packet_type !== want.packet_type ||
                   rsp_payload.payload_length !== want.payload_length) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display({"result %0d: expected status %0d id %h type %h length %0d,",
                               " got status %0d id %h type %h length %0d"},
                              results_checked, want.status, want.message_id,
                              want.packet_type, want.payload_length, rsp_payload.status,
                              rsp_payload.message_id, rsp_payload.packet_type,
                              rsp_payload.payload_length);
                  end
               end
            end
            results_checked++;
         end
         if (req_valid && !req_stall) begin
            absorb_byte(req_payload.data_byte, req_payload.end_of_datagram);
         end
      end
      outstanding = expected_results.size();
   end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import cfr_pkg::*;
   import frame_crc_pkg::*;

   localparam int MAX_FRAME   = 1024;
   localparam int PHASE_BYTES = 210;
   localparam int QUIET_LIMIT = 3000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   int mismatches;
   int outstanding;
   int results_checked;

   int idle_pct;
   int stall_pct;
   int bytes_sent;
   int datagrams_sent;
   int quiet_cycles;
   int phase_mark;

   logic [7:0] frame_bytes[$];

   crc_checked_frame_receiver #(
      .MAX_FRAME(MAX_FRAME)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   frame_status_checker #(
      .MAX_FRAME(MAX_FRAME)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .mismatches     (mismatches),
      .outstanding    (outstanding),
      .results_checked(results_checked)
   );

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      rsp_stall   = 1'b0;
      idle_pct    = 0;
      stall_pct   = 0;
   end

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= !reset && stall_pct != 0 && ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("testbench: errors");
            $finish;
         end
      end
   end

   function automatic logic [7:0] pick_byte(input int fill);
      return (fill < 0) ? 8'($urandom_range(255)) : fill[7:0];
   endfunction

   // Builds a frame with length field len and a correct header CRC and, where
   // len is in range, len bytes with a correct body CRC; else a random tail.
   task automatic build_frame(input int len, input int fill);
      logic [15:0] bits;
      logic [15:0] body;
      logic [7:0]  head;
      logic [2:0]  spare;
      spare = $urandom_range(7);
      bits  = {len[12:0], spare};
      frame_bytes.delete();
      frame_bytes.push_back(pick_byte(fill));
      frame_bytes.push_back(bits[7:0]);
      frame_bytes.push_back(bits[15:8]);
      head = HDR_CRC_INIT;
      for (int i = 0; i < 3; i++) begin
         head = crc8_update(head, frame_bytes[i]);
      end
      frame_bytes.push_back(head);
      if (len >= 11 && len <= MAX_FRAME) begin
         while (frame_bytes.size() < len - 2) begin
            frame_bytes.push_back(pick_byte(fill));
         end
         body = BODY_CRC_INIT;
         for (int i = 0; i < len - 2; i++) begin
            body = crc16_update(body, frame_bytes[i]);
         end
         frame_bytes.push_back(body[7:0]);
         frame_bytes.push_back(body[15:8]);
      end else begin
         repeat ($urandom_range(12)) frame_bytes.push_back(pick_byte(-1));
      end
   endtask

   task automatic trim_to(input int count);
      while (frame_bytes.size() > count) begin
         void'(frame_bytes.pop_back());
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last);
      req_type item;
      item.data_byte       = b;
      item.end_of_datagram = last;
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      bytes_sent++;
   endtask

   task automatic send_datagram();
      for (int i = 0; i < frame_bytes.size(); i++) begin
         send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
      end
      datagrams_sent++;
   endtask

   // Well-formed frames, some with extra bytes, mixed with corrupted, truncated,
   // mislabeled and noise datagrams.
   task automatic random_datagram();
      int         kind;
      int         len;
      logic [7:0] mask;
      kind = $urandom_range(99);
      len  = ($urandom_range(9) == 0) ? $urandom_range(300, 11) : $urandom_range(40, 11);
      mask = 8'h01 << $urandom_range(7);
      if (kind < 45) begin
         build_frame(len, -1);
         if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(6, 1)) frame_bytes.push_back(pick_byte(-1));
         end
      end else if (kind < 60) begin
         build_frame(len, -1);
         kind = $urandom_range(len - 1, 4);
         frame_bytes[kind] = frame_bytes[kind] ^ mask;
      end else if (kind < 68) begin
         build_frame(len, -1);
         frame_bytes[3] = frame_bytes[3] ^ mask;
         if ($urandom_range(1) == 0) begin
            trim_to($urandom_range(len, 4));
         end
      end else if (kind < 78) begin
         build_frame(len, -1);
         trim_to($urandom_range(len - 1, 1));
      end else if (kind < 88) begin
         len = ($urandom_range(1) == 0) ? $urandom_range(10) :
                                          $urandom_range(8191, MAX_FRAME + 1);
         build_frame(len, -1);
      end else begin
         frame_bytes.delete();
         repeat ($urandom_range(16, 1)) frame_bytes.push_back(pick_byte(-1));
      end
   endtask

   initial begin
      int phase_idle[4];
      int phase_stall[4];
      phase_idle     = '{0, 80, 0, 37};
      phase_stall    = '{0, 0, 80, 37};
      bytes_sent     = 0;
      datagrams_sent = 0;
      quiet_cycles   = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Datagrams too short to hold a header.
      frame_bytes.delete();
      frame_bytes.push_back(8'hFF);
      send_datagram();
      frame_bytes.delete();
      repeat (3) frame_bytes.push_back(8'h00);
      send_datagram();
      // Shortest legal frame with all-ones type and id.
      build_frame(11, 255);
      send_datagram();
      // Bad header CRC, datagram ending right after it.
      build_frame(11, 0);
      frame_bytes[3] = frame_bytes[3] ^ 8'h80;
      trim_to(4);
      send_datagram();
      // Length below the minimum.
      build_frame(10, 0);
      frame_bytes.push_back(8'h5A);
      trim_to(5);
      send_datagram();

      for (int ph = 0; ph < 4; ph++) begin
         idle_pct  = phase_idle[ph];
         stall_pct = phase_stall[ph];
         if (ph == 1) begin
            build_frame(MAX_FRAME, -1);
            send_datagram();
         end
         phase_mark = bytes_sent;
         while (bytes_sent - phase_mark < PHASE_BYTES) begin
            random_datagram();
            send_datagram();
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);

      $display("Sent %0d bytes in %0d datagrams over four idle/stall phases.",
               bytes_sent, datagrams_sent);
      $display("Compared %0d frame results, including a maximum-length frame.",
               results_checked);
      if (mismatches == 0 && outstanding == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

>>> files.f
hdl/cfr_pkg.sv
hdl/cfr_input_stage.sv
hdl/cfr_frame_check.sv
hdl/cfr_output_stage.sv
hdl/crc_checked_frame_receiver.sv
bench/frame_status_checker.sv
bench/testbench.sv
